### rtl/ccp_pkg.sv
// shared types, constants and codes of the circle to polygon collision block
package ccp_pkg;

	localparam int MAX_V  = 8;
	localparam int VIDX_W = $clog2(MAX_V);
	localparam int CNT_W  = $clog2(MAX_V + 1);
	localparam int CW     = 16;

	localparam logic [3:0] SIDE_NONE    = 4'd0;
	localparam logic [3:0] SIDE_CORNER0 = 4'd1;
	localparam logic [3:0] SIDE_EDGE0   = 4'd5;
	localparam logic [3:0] SIDE_CORNER  = 4'd9;
	localparam logic [3:0] SIDE_EDGE    = 4'd10;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_17 = 2'd1;
	localparam logic [1:0] SH_34 = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_R2, ST_RDI, ST_RDJ, ST_EDGE, ST_D2, ST_DOT0, ST_DOT1,
		ST_LEN0, ST_LEN1, ST_BIG, ST_CMP, ST_CHK, ST_NUM0, ST_NUM1, ST_DIVS,
		ST_DIVW, ST_DX0, ST_DX1, ST_SQS, ST_SQW, ST_FIN
	} state_t;

	typedef struct packed {
		logic               en;
		logic               clr;
		logic               sub;
		logic [1:0]         sh;
		logic signed [17:0] a;
		logic signed [17:0] b;
	} mac_op_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

### rtl/circle_polygon_collision.sv
// top level: vertex store, query sequencer and result register
// An item with kind 0 stores one polygon vertex; an item with kind 1 runs a
// circle query that walks the stored vertices on one shared multiply-accumulate unit and
// answers with one result. A query squares the radius, then at each vertex tests the
// corner distance, then the edge projection; a vertex whose projection is not positive or
// that projects past the edge end goes on to the next, else the exact overlap test runs.
// A corner hit ends with the square root. An edge hit adds two 18-step divisions and a
// 17-step square root after the overlap test, and every query ends in the result register.
// A query before any polygon has been completed goes straight to the result register.
// The vertex walk is set by the single read port of the vertex store and the one
// multiplier. The query holds in its last cycle while the previous result waits, and the
// block takes no item while a query runs.
module circle_polygon_collision import ccp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic               last_vertex,
	input  logic signed [15:0] circle_x,
	input  logic signed [15:0] circle_y,
	input  logic [14:0]        circle_radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         side_code,
	output logic signed [15:0] contact_x,
	output logic signed [15:0] contact_y,
	output logic signed [15:0] penetration,
	output logic [3:0]         hit_index
);

	state_t state_q, state_n;

	logic signed [15:0] mem_x [MAX_V];
	logic signed [15:0] mem_y [MAX_V];
	logic signed [15:0] rd_x_q, rd_y_q;
	logic [VIDX_W-1:0]  rd_addr;

	logic [CNT_W-1:0]   count_q, pos_q;
	logic [VIDX_W-1:0]  i_q, j_idx;
	logic [2:0]         k_q;
	logic               hit_q, corner_q, axis_q;
	logic signed [15:0] cx_q, cy_q, vx_q, vy_q;
	logic [14:0]        r_q;
	logic [29:0]        r2_q;
	logic signed [16:0] ax_q, ay_q, ex_q, ey_q;
	logic [33:0]        dist2_q, dot_q, len2_q, dd;
	logic signed [17:0] px_q, py_q, dx, dy;
	logic signed [15:0] pen_q;

	logic               out_valid_q;
	logic [3:0]         side_q, idx_q;
	logic signed [15:0] ox_q, oy_q, open_q;

	mac_op_t            mop;
	logic signed [71:0] acc;
	iter_req_t          ireq;
	iter_stat_t         istat;
	logic [17:0]        ires;
	logic [51:0]        inum;
	logic [33:0]        irad;

	logic               in_acc, fin_go, last_i;
	logic signed [16:0] e_sel;
	logic [16:0]        e_abs;
	logic signed [18:0] pen_w;
	logic signed [17:0] p_new;
	logic [3:0]         side_n;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign last_i   = !(({1'b0, i_q} + 4'd1) < count_q);
	assign j_idx    = last_i ? '0 : i_q + 3'd1;
	assign dd       = dist2_q - {4'd0, r2_q};
	assign e_sel    = axis_q ? ey_q : ex_q;
	assign e_abs    = e_sel[16] ? 17'(-e_sel) : 17'(e_sel);
	assign dx       = px_q - 18'(cx_q);
	assign dy       = py_q - 18'(cy_q);
	assign inum     = acc[51:0] + {19'd0, len2_q[33:1]};
	assign irad     = corner_q ? dist2_q : acc[33:0];

	ccp_mac u_mac (.clk(clk), .arst_n(arst_n), .op(mop), .acc(acc));

	ccp_iter u_iter (
		.clk(clk), .arst_n(arst_n), .req(ireq), .num(inum), .den(len2_q),
		.rad(irad), .stat(istat), .res(ires)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		mop     = '0;
		ireq    = '0;
		rd_addr = i_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && kind)
					state_n = (count_q == '0) ? ST_FIN : ST_R2;
			end
			ST_R2: begin
				mop     = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0,
					a: 18'(r_q), b: 18'(r_q)};
				state_n = ST_RDI;
			end
			ST_RDI: state_n = ST_RDJ;
			ST_RDJ: begin
				rd_addr = j_idx;
				state_n = ST_EDGE;
			end
			ST_EDGE: begin
				mop     = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0,
					a: 18'(ax_q), b: 18'(ax_q)};
				state_n = ST_D2;
			end
			ST_D2: begin
				mop     = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0,
					a: 18'(ay_q), b: 18'(ay_q)};
				state_n = ST_DOT0;
			end
			ST_DOT0: begin
				if (acc[33:0] < {4'd0, r2_q}) begin
					state_n = ST_SQS;
				end else begin
					mop     = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0,
						a: 18'(ax_q), b: 18'(ex_q)};
					state_n = ST_DOT1;
				end
			end
			ST_DOT1: begin
				mop     = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0,
					a: 18'(ay_q), b: 18'(ey_q)};
				state_n = ST_LEN0;
			end
			ST_LEN0: begin
				if (acc <= 72'sd0) begin
					state_n = last_i ? ST_FIN : ST_RDI;
				end else begin
					mop     = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0,
						a: 18'(ex_q), b: 18'(ex_q)};
					state_n = ST_LEN1;
				end
			end
			ST_LEN1: begin
				mop     = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0,
					a: 18'(ey_q), b: 18'(ey_q)};
				state_n = ST_BIG;
			end
			ST_BIG: begin
				if (dot_q >= acc[33:0])
					state_n = last_i ? ST_FIN : ST_RDI;
				else
					state_n = ST_CMP;
			end
			ST_CMP: begin
				mop.en = 1'b1;
				case (k_q)
					3'd0: mop = '{1'b1, 1'b1, 1'b0, SH_34,
						{1'b0, dd[33:17]}, {1'b0, len2_q[33:17]}};
					3'd1: mop = '{1'b1, 1'b0, 1'b0, SH_17,
						{1'b0, dd[33:17]}, {1'b0, len2_q[16:0]}};
					3'd2: mop = '{1'b1, 1'b0, 1'b0, SH_17,
						{1'b0, dd[16:0]}, {1'b0, len2_q[33:17]}};
					3'd3: mop = '{1'b1, 1'b0, 1'b0, SH_0,
						{1'b0, dd[16:0]}, {1'b0, len2_q[16:0]}};
					3'd4: mop = '{1'b1, 1'b0, 1'b1, SH_34,
						{1'b0, dot_q[33:17]}, {1'b0, dot_q[33:17]}};
					3'd5: mop = '{1'b1, 1'b0, 1'b1, SH_17,
						{1'b0, dot_q[33:17]}, {1'b0, dot_q[16:0]}};
					3'd6: mop = '{1'b1, 1'b0, 1'b1, SH_17,
						{1'b0, dot_q[16:0]}, {1'b0, dot_q[33:17]}};
					default: mop = '{1'b1, 1'b0, 1'b1, SH_0,
						{1'b0, dot_q[16:0]}, {1'b0, dot_q[16:0]}};
				endcase
				if (k_q == 3'd7)
					state_n = ST_CHK;
			end
			ST_CHK: begin
				if (acc <= 72'sd0)
					state_n = ST_NUM0;
				else
					state_n = last_i ? ST_FIN : ST_RDI;
			end
			ST_NUM0: begin
				mop     = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0,
					a: {1'b0, e_abs}, b: {1'b0, dot_q[16:0]}};
				state_n = ST_NUM1;
			end
			ST_NUM1: begin
				mop     = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_17,
					a: {1'b0, e_abs}, b: {1'b0, dot_q[33:17]}};
				state_n = ST_DIVS;
			end
			ST_DIVS: begin
				ireq    = '{start: 1'b1, sqrt: 1'b0};
				state_n = ST_DIVW;
			end
			ST_DIVW: begin
				if (istat.done)
					state_n = axis_q ? ST_DX0 : ST_NUM0;
			end
			ST_DX0: begin
				mop     = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0, a: dx, b: dx};
				state_n = ST_DX1;
			end
			ST_DX1: begin
				mop     = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0, a: dy, b: dy};
				state_n = ST_SQS;
			end
			ST_SQS: begin
				ireq    = '{start: 1'b1, sqrt: 1'b1};
				state_n = ST_SQW;
			end
			ST_SQW: begin
				if (istat.done)
					state_n = ST_FIN;
			end
			ST_FIN: begin
				if (fin_go)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// vertex store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && !kind && (pos_q < CNT_W'(MAX_V))) begin
			mem_x[pos_q[VIDX_W-1:0]] <= vertex_x;
			mem_y[pos_q[VIDX_W-1:0]] <= vertex_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
		end else if (in_acc && !kind) begin
			if (last_vertex) begin
				count_q <= (pos_q < CNT_W'(MAX_V)) ? pos_q + 1'b1 : CNT_W'(MAX_V);
				pos_q   <= '0;
			end else if (pos_q < CNT_W'(MAX_V)) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign p_new = (axis_q ? 18'(vy_q) : 18'(vx_q))
		+ (e_sel[16] ? -18'(ires[16:0]) : 18'(ires[16:0]));
	assign pen_w = 19'(r_q) - 19'(ires);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q   <= circle_x;
				cy_q   <= circle_y;
				r_q    <= circle_radius;
				i_q    <= '0;
				hit_q  <= 1'b0;
				axis_q <= 1'b0;
			end
			ST_RDI: begin
				if (i_q == '0)
					r2_q <= acc[29:0];
			end
			ST_RDJ: begin
				vx_q <= rd_x_q;
				vy_q <= rd_y_q;
				ax_q <= 17'(cx_q) - 17'(rd_x_q);
				ay_q <= 17'(cy_q) - 17'(rd_y_q);
			end
			ST_EDGE: begin
				ex_q <= 17'(rd_x_q) - 17'(vx_q);
				ey_q <= 17'(rd_y_q) - 17'(vy_q);
			end
			ST_DOT0: begin
				dist2_q  <= acc[33:0];
				px_q     <= 18'(vx_q);
				py_q     <= 18'(vy_q);
				if (acc[33:0] < {4'd0, r2_q}) begin
					hit_q    <= 1'b1;
					corner_q <= 1'b1;
				end
			end
			ST_LEN0: begin
				dot_q <= acc[33:0];
				if (acc <= 72'sd0 && !last_i)
					i_q <= i_q + 1'b1;
			end
			ST_BIG: begin
				len2_q <= acc[33:0];
				k_q    <= '0;
				if (dot_q >= acc[33:0] && !last_i)
					i_q <= i_q + 1'b1;
			end
			ST_CMP: k_q <= k_q + 3'd1;
			ST_CHK: begin
				if (acc <= 72'sd0) begin
					hit_q    <= 1'b1;
					corner_q <= 1'b0;
				end else if (!last_i) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_DIVW: begin
				if (istat.done) begin
					axis_q <= 1'b1;
					if (axis_q)
						py_q <= p_new;
					else
						px_q <= p_new;
				end
			end
			ST_SQW: begin
				if (istat.done)
					pen_q <= (pen_w < -19'sd32768) ? -16'sd32768 : 16'(pen_w);
			end
			default: ;
		endcase
	end

	always_comb begin
		if (!hit_q)
			side_n = SIDE_NONE;
		else if (count_q > CNT_W'(4))
			side_n = corner_q ? SIDE_CORNER : SIDE_EDGE;
		else
			side_n = (corner_q ? SIDE_CORNER0 : SIDE_EDGE0) + 4'(i_q);
	end

	function automatic logic signed [15:0] clamp16(input logic signed [17:0] v);
		if (v > 18'sd32767)
			return 16'sd32767;
		else if (v < -18'sd32768)
			return -16'sd32768;
		else
			return 16'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			side_q <= side_n;
			ox_q   <= hit_q ? clamp16(px_q) : '0;
			oy_q   <= hit_q ? clamp16(py_q) : '0;
			open_q <= hit_q ? pen_q : '0;
			idx_q  <= hit_q ? 4'(i_q) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign side_code   = side_q;
	assign contact_x   = ox_q;
	assign contact_y   = oy_q;
	assign penetration = open_q;
	assign hit_index   = idx_q;

`ifndef SYNTHESIS
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side_code == SIDE_NONE |->
		contact_x == 16'sd0 && penetration == 16'sd0 && hit_index == 4'd0)
		else $error("no-hit result carries nonzero fields");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_V) && pos_q <= CNT_W'(MAX_V))
		else $error("vertex count or load position beyond store depth");
	a_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ireq.start |-> !istat.busy)
		else $error("shared divide/sqrt unit restarted while busy");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && state_q == ST_FIN |=> state_q == ST_FIN)
		else $error("result finished while previous item not taken");
`endif

endmodule

### rtl/ccp_mac.sv
// shared 18x18 signed multiply-accumulate unit with shifted accumulation
module ccp_mac import ccp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_op_t            op,
	output logic signed [71:0] acc
);

	logic signed [71:0] acc_q;
	logic signed [35:0] prod;
	logic signed [71:0] prod_ext;
	logic signed [71:0] prod_sh;
	logic signed [71:0] base;

	assign prod     = op.a * op.b;
	assign prod_ext = {{36{prod[35]}}, prod};
	assign base     = op.clr ? 72'sd0 : acc_q;

	always_comb begin
		case (op.sh)
			SH_0:    prod_sh = prod_ext;
			SH_17:   prod_sh = prod_ext <<< 17;
			SH_34:   prod_sh = prod_ext <<< 34;
			default: prod_sh = prod_ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op.en) begin
			acc_q <= op.sub ? base - prod_sh : base + prod_sh;
		end
	end

	assign acc = acc_q;

endmodule

### rtl/ccp_iter.sv
// iterative restoring divider and integer square root on one shared subtractor
module ccp_iter import ccp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  iter_req_t   req,
	input  logic [51:0] num,
	input  logic [33:0] den,
	input  logic [33:0] rad,
	output iter_stat_t  stat,
	output logic [17:0] res
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic        mode_q;
	logic [51:0] rem_q;
	logic [33:0] acc_q;
	logic [50:0] sh_q;
	logic [51:0] cand;
	logic        ge;
	logic [33:0] s_up;

	assign s_up = acc_q + sh_q[33:0];
	assign cand = mode_q ? {18'd0, s_up} : {1'b0, sh_q};
	assign ge   = rem_q >= cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.sqrt ? 5'd16 : 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.sqrt;
			acc_q  <= '0;
			if (req.sqrt) begin
				rem_q <= {18'd0, rad};
				sh_q  <= 51'd1 << 32;
			end else begin
				rem_q <= num;
				sh_q  <= {den, 17'd0};
			end
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - cand;
			if (mode_q) begin
				acc_q <= ge ? (acc_q >> 1) + sh_q[33:0] : acc_q >> 1;
				sh_q  <= sh_q >> 2;
			end else begin
				acc_q <= {acc_q[32:0], ge};
				sh_q  <= sh_q >> 1;
			end
		end
	end

	always_comb begin
		if (mode_q)
			res = (rem_q > {18'd0, acc_q}) ? acc_q[17:0] + 18'd1 : acc_q[17:0];
		else
			res = acc_q[17:0];
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
